// ===== sv/mtrs_pkg.sv =====
// Shared constants, codes and types of the Modbus TCP register read server.
package mtrs_pkg;

  localparam int TBL_ENTRIES = 64;
  localparam int TBL_AW      = $clog2(TBL_ENTRIES);
  localparam int MAX_QTY     = 125;
  localparam int FRAME_BYTES = 12;
  localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
  localparam int VBUF_DEPTH  = 128;
  localparam int VBUF_AW     = $clog2(VBUF_DEPTH);

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] ST_DATA      = 3'd0;
  localparam logic [2:0] ST_EXCEPTION = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [2:0] ST_BAD_PROTO = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;
  localparam logic [2:0] ST_STORED    = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;
  localparam logic [2:0] ST_CLEARED   = 3'd7;

  localparam logic [7:0] FUNC_HOLDING = 8'h03;
  localparam logic [7:0] FUNC_INPUT   = 8'h04;
  localparam logic [7:0] EXC_FLAG     = 8'h80;
  localparam logic [7:0] EXC_FUNC     = 8'h01;
  localparam logic [7:0] EXC_ADDR     = 8'h02;
  localparam logic [7:0] EXC_VALUE    = 8'h03;
  localparam logic [15:0] MBAP_LEN    = 16'd6;

  typedef enum logic [1:0] {T_IDLE, T_READ, T_CMP} tbl_state_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_LOADGO, S_LOAD, S_LOOK, S_LWAIT, S_HDR, S_VRD1, S_VRD2, S_VEMIT
  } srv_state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  unit;
    logic [15:0] address;
    logic [15:0] value;
  } tbl_entry_t;

  typedef struct packed {
    logic        start;
    logic        kind;
    logic [7:0]  unit;
    logic [15:0] address;
  } srch_req_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [TBL_AW-1:0] hit_idx;
    logic              free_found;
    logic [TBL_AW-1:0] free_idx;
  } srch_rsp_t;

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] idx;
    tbl_entry_t        entry;
  } tbl_wr_t;

endpackage

// ===== sv/mtrs_table.sv =====
// Register table memory with valid bits and a one-entry-per-step key search unit.
module mtrs_table
  import mtrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  srch_req_t  req,
  input  tbl_wr_t    wr,
  input  logic       clear,
  output srch_rsp_t  rsp,
  output logic [15:0] hit_value
);

  tbl_entry_t        mem [TBL_ENTRIES];
  logic [TBL_ENTRIES-1:0] valid;
  tbl_entry_t        rdata;
  tbl_state_t        state, state_next;
  logic [TBL_AW-1:0] idx;
  logic              key_kind;
  logic [7:0]        key_unit;
  logic [15:0]       key_address;
  logic              match;
  logic              last_idx;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.entry;
    end
    if (state == T_READ) begin
      rdata <= mem[idx];
    end
  end

  assign match = valid[idx] && rdata.kind == key_kind && rdata.unit == key_unit
                 && rdata.address == key_address;
  assign last_idx = idx == TBL_AW'(TBL_ENTRIES - 1);

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE: if (req.start) state_next = T_READ;
      T_READ: state_next = T_CMP;
      T_CMP: begin
        if (match || last_idx) state_next = T_IDLE;
        else state_next = T_READ;
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      valid    <= '0;
      rsp.done <= 1'b0;
    end else begin
      state    <= state_next;
      rsp.done <= 1'b0;
      if (clear) begin
        valid <= '0;
      end else if (wr.en) begin
        valid[wr.idx] <= 1'b1;
      end
      unique case (state)
        T_IDLE: begin
          if (req.start) begin
            idx            <= '0;
            key_kind       <= req.kind;
            key_unit       <= req.unit;
            key_address    <= req.address;
            rsp.found      <= 1'b0;
            rsp.free_found <= 1'b0;
          end
        end
        T_READ: ;
        T_CMP: begin
          // The first free slot is remembered in case the key is not present.
          if (!valid[idx] && !rsp.free_found) begin
            rsp.free_found <= 1'b1;
            rsp.free_idx   <= idx;
          end
          if (match) begin
            rsp.found   <= 1'b1;
            rsp.hit_idx <= idx;
            hit_value   <= rdata.value;
            rsp.done    <= 1'b1;
          end else if (last_idx) begin
            rsp.done <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_done_after_cmp: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(state) == T_CMP) else $error("search done without compare");
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    rsp.done && rsp.found |-> valid[rsp.hit_idx]) else $error("hit on invalid entry");
  a_free_empty: assert property (@(posedge clk) disable iff (rst)
    rsp.done && !rsp.found && rsp.free_found |-> !valid[rsp.free_idx])
    else $error("free slot reported while valid");

endmodule

// ===== sv/modbus_tcp_read_register_server.sv =====
// Top level: frame collection, request checks, read sequencer and response output.
//  channel | direction | tuser          | tdata / tlast
//  s_*     | in        | cmd            | frame_byte, reg_kind, reg_unit, reg_address,
//          |           |                | reg_value / frame_last
//  m_*     | out       | status,item_kind | response fields / resp_last
// A frame byte that is not last leaves the server idle; a clear answers on the next cycle.
// A load searches the 64-entry table for its key or a free slot, one entry at a time.
// A read searches the table once per requested register, then sends a header item and
// value items of up to two values each.
// Reset clears the table valid bits, the frame fill and the exchange count at once.
// Input is held off while any response item waits on the output register.
module modbus_tcp_read_register_server
  import mtrs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   s_tuser,  // cmd
  input  logic         s_tlast,  // frame_last
  input  logic [55:0]  s_tdata,  // frame_byte, reg_kind, reg_unit, reg_address, reg_value
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [3:0]   m_tuser,  // status, item_kind
  output logic         m_tlast,  // resp_last
  // txn_id, resp_unit, resp_function, mbap_length, count_or_exception,
  // value_first, value_second, second_valid, exchange_total
  output logic [103:0] m_tdata
);

  srv_state_t        state, state_next;
  logic [7:0]        frame_store [FRAME_BYTES];
  logic [FILL_W-1:0] frame_fill;
  logic              frame_over;
  logic [15:0]       exchange_counter;
  logic [15:0]       vbuf [VBUF_DEPTH];
  logic [15:0]       vbuf_rd;
  logic [15:0]       first_val;

  logic [15:0] tid_r, start_r;
  logic [7:0]  unit_r, func_r;
  logic        kind_r;
  logic [VBUF_AW-1:0] qty_r, pos;
  logic        ld_kind;
  logic [7:0]  ld_unit;
  logic [15:0] ld_address, ld_value;

  logic [2:0]  o_status;
  logic        o_kind, o_sv, o_last;
  logic [15:0] o_tid, o_v1, o_v2;
  logic [7:0]  o_unit, o_func, o_mlen, o_cnt;

  srch_req_t   req;
  srch_rsp_t   rsp;
  tbl_wr_t     wr;
  logic        clear;
  logic [15:0] hit_value;

  logic        accept, out_free;
  logic        size_ok, proto_ok, len_ok, func_ok, param_ok;
  logic [15:0] f_qty;
  logic        val_two, val_last;

  mtrs_table u_table (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .wr        (wr),
    .clear     (clear),
    .rsp       (rsp),
    .hit_value (hit_value)
  );

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign f_qty    = {frame_store[10], frame_store[11]};
  assign size_ok  = !frame_over && frame_fill == FILL_W'(FRAME_BYTES);
  assign proto_ok = {frame_store[2], frame_store[3]} == 16'd0;
  assign len_ok   = {frame_store[4], frame_store[5]} == MBAP_LEN;
  assign func_ok  = frame_store[7] == FUNC_HOLDING || frame_store[7] == FUNC_INPUT;
  assign param_ok = frame_store[6] != 8'd0 && f_qty != 16'd0 && f_qty <= 16'(MAX_QTY);

  assign val_two  = ({1'b0, pos} + 8'd1) < {1'b0, qty_r};
  assign val_last = ({1'b0, pos} + 8'd2) >= {1'b0, qty_r};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (s_tuser)
            CMD_BYTE: if (s_tlast) state_next = S_CHECK;
            CMD_LOAD: state_next = S_LOADGO;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        if (size_ok && proto_ok && len_ok && func_ok && param_ok) state_next = S_LOOK;
        else state_next = S_IDLE;
      end
      S_LOADGO: state_next = S_LOAD;
      S_LOAD:   if (rsp.done) state_next = S_IDLE;
      S_LOOK:   state_next = S_LWAIT;
      S_LWAIT: begin
        if (rsp.done) begin
          if (!rsp.found) state_next = S_IDLE;
          else if (pos == qty_r - 1'b1) state_next = S_HDR;
          else state_next = S_LOOK;
        end
      end
      S_HDR:  if (out_free) state_next = S_VRD1;
      S_VRD1: state_next = S_VRD2;
      S_VRD2: state_next = S_VEMIT;
      S_VEMIT: begin
        if (out_free) state_next = val_last ? S_IDLE : S_VRD1;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = state == S_IDLE && !m_tvalid;
    clear    = accept && s_tuser == CMD_CLEAR;
    req.start   = state == S_LOADGO || state == S_LOOK;
    req.kind    = (state == S_LOOK) ? kind_r : ld_kind;
    req.unit    = (state == S_LOOK) ? unit_r : ld_unit;
    req.address = (state == S_LOOK) ? start_r + {{(16-VBUF_AW){1'b0}}, pos} : ld_address;
    wr.en       = state == S_LOAD && rsp.done && (rsp.found || rsp.free_found);
    wr.idx      = rsp.found ? rsp.hit_idx : rsp.free_idx;
    wr.entry    = '{kind: ld_kind, unit: ld_unit, address: ld_address, value: ld_value};
  end

  always_ff @(posedge clk) begin
    if (state == S_LWAIT && rsp.done && rsp.found) begin
      vbuf[pos] <= hit_value;
    end
    if (state == S_VRD1) begin
      vbuf_rd <= vbuf[pos];
    end else if (state == S_VRD2) begin
      vbuf_rd <= vbuf[pos + 1'b1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      frame_fill       <= '0;
      frame_over       <= 1'b0;
      exchange_counter <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      state <= state_next;
      // A value item that follows straight on the one being taken keeps the output valid.
      if (m_tvalid && m_tready && !(state == S_VEMIT && out_free)) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            o_kind <= 1'b0; o_tid <= '0; o_unit <= '0; o_func <= '0; o_mlen <= '0;
            o_cnt <= '0; o_v1 <= '0; o_v2 <= '0; o_sv <= 1'b0; o_last <= 1'b1;
            unique case (s_tuser)
              CMD_BYTE: begin
                if (frame_fill < FILL_W'(FRAME_BYTES)) begin
                  frame_store[frame_fill[FILL_W-1:0]] <= s_tdata[7:0];
                  frame_fill <= frame_fill + 1'b1;
                end else begin
                  frame_over <= 1'b1;
                end
              end
              CMD_LOAD: begin
                ld_kind    <= s_tdata[8];
                ld_unit    <= s_tdata[16:9];
                ld_address <= s_tdata[32:17];
                ld_value   <= s_tdata[48:33];
              end
              CMD_CLEAR: begin
                exchange_counter <= '0;
                o_status <= ST_CLEARED;
                m_tvalid <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_CHECK: begin
          if (exchange_counter != 16'hFFFF) exchange_counter <= exchange_counter + 1'b1;
          frame_fill <= '0;
          frame_over <= 1'b0;
          tid_r   <= {frame_store[0], frame_store[1]};
          unit_r  <= frame_store[6];
          func_r  <= frame_store[7];
          kind_r  <= frame_store[7] == FUNC_INPUT;
          start_r <= {frame_store[8], frame_store[9]};
          qty_r   <= f_qty[VBUF_AW-1:0];
          pos     <= '0;
          if (!size_ok) begin
            o_status <= ST_BAD_SIZE; m_tvalid <= 1'b1;
          end else if (!proto_ok) begin
            o_status <= ST_BAD_PROTO; m_tvalid <= 1'b1;
          end else if (!len_ok) begin
            o_status <= ST_BAD_LEN; m_tvalid <= 1'b1;
          end else if (!func_ok || !param_ok) begin
            o_status <= ST_EXCEPTION;
            o_tid    <= {frame_store[0], frame_store[1]};
            o_unit   <= frame_store[6];
            o_func   <= frame_store[7] | EXC_FLAG;
            o_mlen   <= 8'd3;
            o_cnt    <= func_ok ? EXC_VALUE : EXC_FUNC;
            m_tvalid <= 1'b1;
          end
        end
        S_LOADGO: ;
        S_LOAD: begin
          if (rsp.done) begin
            o_status <= (rsp.found || rsp.free_found) ? ST_STORED : ST_FULL;
            m_tvalid <= 1'b1;
          end
        end
        S_LOOK: ;
        S_LWAIT: begin
          if (rsp.done) begin
            if (!rsp.found) begin
              o_status <= ST_EXCEPTION;
              o_tid    <= tid_r;
              o_unit   <= unit_r;
              o_func   <= func_r | EXC_FLAG;
              o_mlen   <= 8'd3;
              o_cnt    <= EXC_ADDR;
              m_tvalid <= 1'b1;
            end else if (pos == qty_r - 1'b1) begin
              pos <= '0;
            end else begin
              pos <= pos + 1'b1;
            end
          end
        end
        S_HDR: begin
          if (out_free) begin
            o_status <= ST_DATA;
            o_kind   <= 1'b0;
            o_tid    <= tid_r;
            o_unit   <= unit_r;
            o_func   <= func_r;
            o_cnt    <= {qty_r, 1'b0};
            o_mlen   <= {qty_r, 1'b0} + 8'd3;
            o_v1     <= '0;
            o_v2     <= '0;
            o_sv     <= 1'b0;
            o_last   <= 1'b0;
            m_tvalid <= 1'b1;
          end
        end
        S_VRD1: ;
        S_VRD2: first_val <= vbuf_rd;
        S_VEMIT: begin
          if (out_free) begin
            o_kind   <= 1'b1;
            o_v1     <= first_val;
            o_v2     <= val_two ? vbuf_rd : 16'd0;
            o_sv     <= val_two;
            o_last   <= val_last;
            m_tvalid <= 1'b1;
            pos      <= pos + 2'd2;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tuser = {o_kind, o_status};
  assign m_tlast = o_last;
  assign m_tdata = {7'd0, exchange_counter, o_sv, o_v2, o_v1, o_cnt, o_mlen, o_func,
                    o_unit, o_tid};

endmodule

// ===== tb/tb_modbus_tcp_read_register_server.sv =====
// Testbench for the Modbus TCP register read server: directed table, checked random traffic, table fill.
`timescale 1ns / 1ps

module tb_modbus_tcp_read_register_server;
  import mtrs_pkg::*;

  localparam int QUIET_LIMIT = 100000;

  typedef struct packed {
    logic [2:0]  status;
    logic        item_kind;
    logic [15:0] tid;
    logic [7:0]  unit;
    logic [7:0]  func;
    logic [7:0]  mlen;
    logic [7:0]  cnt;
    logic [15:0] v1;
    logic [15:0] v2;
    logic        v2_ok;
    logic        last;
    logic [15:0] total;
  } resp_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  fbyte;
    logic        flast;
    logic        kind;
    logic [7:0]  unit;
    logic [15:0] addr;
    logic [15:0] val;
  } req_t;

  typedef struct {
    req_t  req;
    bit    typed;
    resp_t exp;
  } row_t;

  logic         clk, rst;
  logic         s_tvalid, s_tready, s_tlast;
  logic [1:0]   s_tuser;
  logic [55:0]  s_tdata;
  logic         m_tvalid, m_tready, m_tlast;
  logic [3:0]   m_tuser;
  logic [103:0] m_tdata;

  modbus_tcp_read_register_server DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tlast(s_tlast),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tlast(m_tlast),
    .m_tdata(m_tdata)
  );

  // Predictor state.
  logic [7:0]  fr_buf [FRAME_BYTES];
  int          fr_fill;
  bit          fr_over;
  bit          tv_valid [TBL_ENTRIES];
  logic        tv_kind  [TBL_ENTRIES];
  logic [7:0]  tv_unit  [TBL_ENTRIES];
  logic [15:0] tv_addr  [TBL_ENTRIES];
  logic [15:0] tv_val   [TBL_ENTRIES];
  logic [15:0] xchg_cnt;

  resp_t pending_resp [$];
  row_t  directed [$];
  int    errors;
  int    quiet;
  int    tx_idle, rx_idle;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input resp_t got, input resp_t exp);
    $display("MISMATCH %s: got %h expected %h", what, got, exp);
    errors++;
  endtask

  function automatic void expect_item(input resp_t r);
    pending_resp.insert(pending_resp.size(), r);
  endfunction

  function automatic resp_t simple_resp(input logic [2:0] st, input logic [15:0] total);
    resp_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    r.total = total;
    return r;
  endfunction

  function automatic int lookup_entry(input logic kind, input logic [7:0] unit,
                                      input logic [15:0] addr);
    for (int i = 0; i < TBL_ENTRIES; i++)
      if (tv_valid[i] && tv_kind[i] == kind && tv_unit[i] == unit && tv_addr[i] == addr)
        return i;
    return -1;
  endfunction

  function automatic logic [15:0] frame_word(input int at);
    return {fr_buf[at], fr_buf[at+1]};
  endfunction

  function automatic void answer_frame();
    logic [15:0] tid, start, qty;
    logic [7:0]  unit, func;
    logic [15:0] vals [$];
    resp_t       r;
    int          e;
    if (xchg_cnt != 16'hFFFF) xchg_cnt++;
    if (fr_over || fr_fill != FRAME_BYTES) begin
      expect_item(simple_resp(ST_BAD_SIZE, xchg_cnt));
      return;
    end
    if (frame_word(2) != 16'd0) begin
      expect_item(simple_resp(ST_BAD_PROTO, xchg_cnt));
      return;
    end
    if (frame_word(4) != MBAP_LEN) begin
      expect_item(simple_resp(ST_BAD_LEN, xchg_cnt));
      return;
    end
    tid = frame_word(0);
    unit = fr_buf[6];
    func = fr_buf[7];
    start = frame_word(8);
    qty = frame_word(10);
    r = simple_resp(ST_EXCEPTION, xchg_cnt);
    r.tid = tid;
    r.unit = unit;
    r.func = func | EXC_FLAG;
    r.mlen = 8'd3;
    if (func != FUNC_HOLDING && func != FUNC_INPUT) begin
      r.cnt = EXC_FUNC;
      expect_item(r);
      return;
    end
    if (unit == 0 || qty == 0 || qty > MAX_QTY) begin
      r.cnt = EXC_VALUE;
      expect_item(r);
      return;
    end
    for (int i = 0; i < qty; i++) begin
      e = lookup_entry(func == FUNC_INPUT, unit, 16'(start + i));
      if (e < 0) begin
        r.cnt = EXC_ADDR;
        expect_item(r);
        return;
      end
      vals.insert(vals.size(), tv_val[e]);
    end
    r = simple_resp(ST_DATA, xchg_cnt);
    r.last = 1'b0;
    r.tid = tid;
    r.unit = unit;
    r.func = func;
    r.mlen = 8'(3 + 2 * qty);
    r.cnt = 8'(2 * qty);
    expect_item(r);
    r.item_kind = 1'b1;
    for (int i = 0; i < qty; i += 2) begin
      r.v1 = vals[i];
      r.v2_ok = (i + 1) < qty;
      r.v2 = r.v2_ok ? vals[i+1] : 16'd0;
      r.last = (i + 2) >= qty;
      expect_item(r);
    end
  endfunction

  function automatic void predict_server_response(input req_t q);
    int e;
    case (q.cmd)
      CMD_BYTE: begin
        if (fr_fill < FRAME_BYTES) begin
          fr_buf[fr_fill] = q.fbyte;
          fr_fill++;
        end else fr_over = 1;
        if (q.flast) begin
          answer_frame();
          fr_fill = 0;
          fr_over = 0;
        end
      end
      CMD_LOAD: begin
        e = lookup_entry(q.kind, q.unit, q.addr);
        if (e < 0)
          for (int i = 0; i < TBL_ENTRIES; i++)
            if (!tv_valid[i]) begin
              e = i;
              break;
            end
        if (e < 0) expect_item(simple_resp(ST_FULL, xchg_cnt));
        else begin
          tv_valid[e] = 1;
          tv_kind[e] = q.kind;
          tv_unit[e] = q.unit;
          tv_addr[e] = q.addr;
          tv_val[e] = q.val;
          expect_item(simple_resp(ST_STORED, xchg_cnt));
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < TBL_ENTRIES; i++) tv_valid[i] = 0;
        xchg_cnt = 0;
        expect_item(simple_resp(ST_CLEARED, xchg_cnt));
      end
      default: ;
    endcase
  endfunction

  // Presents one item and returns at the edge where it is taken.
  task automatic send_req(input req_t q);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= q.cmd;
    s_tlast <= q.flast;
    s_tdata <= {7'd0, q.val, q.addr, q.unit, q.kind, q.fbyte};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic req_t noise_req(input logic [1:0] cmd);
    req_t q;
    q.cmd = cmd;
    q.fbyte = 8'($urandom);
    q.flast = 1'($urandom);
    q.kind = 1'($urandom);
    q.unit = 8'($urandom);
    q.addr = 16'($urandom);
    q.val = 16'($urandom);
    return q;
  endfunction

  task automatic send_checked(input req_t q);
    send_req(q);
    predict_server_response(q);
  endtask

  task automatic send_frame(input logic [7:0] bytes [$]);
    req_t q;
    foreach (bytes[i]) begin
      q = noise_req(CMD_BYTE);
      q.fbyte = bytes[i];
      q.flast = (i == bytes.size() - 1);
      send_checked(q);
    end
  endtask

  function automatic logic [15:0] pool_addr();
    return 16'(16'hFFF8 + $urandom_range(15));
  endfunction

  function automatic logic [7:0] pool_unit();
    case ($urandom_range(3))
      0: return 8'd1;
      1: return 8'd2;
      2: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_load(input logic kind, input logic [7:0] unit, input logic [15:0] addr);
    req_t q;
    q = noise_req(CMD_LOAD);
    q.kind = kind;
    q.unit = unit;
    q.addr = addr;
    send_checked(q);
  endtask

  task automatic send_read(input logic [7:0] func, input logic [7:0] unit,
                           input logic [15:0] start, input logic [15:0] qty);
    logic [15:0]  tid;
    logic [7:0]   b [$];
    tid = 16'($urandom);
    b = '{tid[15:8], tid[7:0], 8'd0, 8'd0, 8'd0, 8'd6, unit, func,
          start[15:8], start[7:0], qty[15:8], qty[7:0]};
    send_frame(b);
  endtask

  task automatic random_frame();
    logic [15:0] tid, start, qty, proto, mlen;
    logic [7:0]  unit, func;
    logic [7:0]  b [$];
    int          r, n;
    r = $urandom_range(99);
    tid = 16'($urandom);
    unit = pool_unit();
    func = $urandom_range(1) ? FUNC_INPUT : FUNC_HOLDING;
    start = pool_addr();
    qty = 16'($urandom_range(1, 6));
    proto = 16'd0;
    mlen = MBAP_LEN;
    if (r >= 60 && r < 66) proto = 16'($urandom_range(1, 65535));
    else if (r >= 66 && r < 72) mlen = 16'($urandom) ^ (16'd1 << $urandom_range(15));
    else if (r >= 82 && r < 86) begin
      func = 8'($urandom);
      if (func == FUNC_HOLDING || func == FUNC_INPUT) func = 8'hFF;
    end else if (r >= 86 && r < 90) unit = 8'd0;
    else if (r >= 90 && r < 94)
      qty = $urandom_range(2) == 0 ? 16'd0 : ($urandom_range(1) ? 16'(MAX_QTY) :
            16'($urandom_range(MAX_QTY + 1, 65535)));
    else if (r >= 94) start = 16'($urandom);
    b = '{tid[15:8], tid[7:0], proto[15:8], proto[7:0], mlen[15:8], mlen[7:0], unit, func,
          start[15:8], start[7:0], qty[15:8], qty[7:0]};
    if (r >= 72 && r < 78) begin
      n = $urandom_range(1, 11);
      while (b.size() > n) void'(b.pop_back());
    end else if (r >= 78 && r < 82) begin
      n = $urandom_range(1, 3);
      repeat (n) b.insert(b.size(), 8'($urandom));
    end
    send_frame(b);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int items);
    int sent, r;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(99);
      if (r < 30) begin
        send_load(1'($urandom), pool_unit(), $urandom_range(3) == 0 ? 16'($urandom) : pool_addr());
        sent++;
      end else if (r < 93) begin
        random_frame();
        sent += 12;
      end else if (r < 96) begin
        send_checked(noise_req(CMD_CLEAR));
        sent++;
      end else begin
        send_checked(noise_req(2'd3));
      end
    end
  endtask

  task automatic add_row(input req_t q, input bit typed, input resp_t exp);
    row_t w;
    w.req = q;
    w.typed = typed;
    w.exp = exp;
    directed.insert(directed.size(), w);
  endtask

  // Monitor, checker and quiet-cycle watchdog.
  always @(posedge clk) begin
    resp_t got, exp;
    if (rst) quiet <= 0;
    else begin
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (m_tvalid && m_tready) begin
        got = {m_tuser[2:0], m_tuser[3], m_tdata[15:0], m_tdata[23:16], m_tdata[31:24],
               m_tdata[39:32], m_tdata[47:40], m_tdata[63:48], m_tdata[79:64], m_tdata[80],
               m_tlast, m_tdata[96:81]};
        if (pending_resp.size() == 0) report_mismatch("unexpected item", got, '0);
        else begin
          exp = pending_resp.pop_front();
          if (got !== exp) report_mismatch("item fields", got, exp);
        end
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_modbus_tcp_read_register_server NOT OK");
        $finish;
      end
    end
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= rx_idle);

  initial begin
    req_t q;
    int   before_n;
    logic [7:0] hb [$];
    errors = 0;
    tx_idle = 0;
    rx_idle = 0;
    fr_fill = 0;
    fr_over = 0;
    xchg_cnt = 0;
    for (int i = 0; i < TBL_ENTRIES; i++) tv_valid[i] = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = CMD_BYTE;
    s_tlast = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: clear, extreme loads, an overwrite, a wrapping read, a one-byte frame, an unknown command.
    q = noise_req(CMD_CLEAR);
    add_row(q, 1, simple_resp(ST_CLEARED, 16'd0));
    q = noise_req(CMD_LOAD); q.kind = 0; q.unit = 8'd1; q.addr = 16'hFFFF; q.val = 16'hFFFF;
    add_row(q, 1, simple_resp(ST_STORED, 16'd0));
    q.addr = 16'h0000; q.val = 16'h0000;
    add_row(q, 1, simple_resp(ST_STORED, 16'd0));
    q.kind = 1; q.unit = 8'd255; q.addr = 16'h1234; q.val = 16'hA5A5;
    add_row(q, 1, simple_resp(ST_STORED, 16'd0));
    q.val = 16'h5A5A;  // same key: overwrite
    add_row(q, 1, simple_resp(ST_STORED, 16'd0));
    hb = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h06, 8'h01, FUNC_HOLDING,
           8'hFF, 8'hFF, 8'h00, 8'h02};
    foreach (hb[i]) begin
      q = noise_req(CMD_BYTE); q.fbyte = hb[i]; q.flast = (i == 11);
      add_row(q, 0, '0);
    end
    q = noise_req(CMD_BYTE); q.flast = 1;
    add_row(q, 1, simple_resp(ST_BAD_SIZE, 16'd2));
    q = noise_req(2'd3);
    add_row(q, 0, '0);
    foreach (directed[i]) begin
      send_req(directed[i].req);
      before_n = pending_resp.size();
      predict_server_response(directed[i].req);
      if (directed[i].typed) begin
        while (pending_resp.size() > before_n) void'(pending_resp.pop_back());
        expect_item(directed[i].exp);
      end
    end
    send_read(FUNC_INPUT, 8'd255, 16'h1234, 16'd1);
    wait_drained();

    tx_idle = 14;
    rx_idle = 76;
    random_phase(80);
    wait_drained();

    tx_idle = 76;
    rx_idle = 14;
    random_phase(80);
    wait_drained();

    // Fill the table, overflow it, read all of it in one response, then clear it and run random traffic.
    tx_idle = 0;
    rx_idle = 0;
    send_checked(noise_req(CMD_CLEAR));
    for (int i = 0; i < TBL_ENTRIES; i++) send_load(1'b0, 8'd7, 16'(16'hFFE0 + i));
    send_load(1'b1, 8'd7, 16'h0000);
    send_read(FUNC_HOLDING, 8'd7, 16'hFFE0, 16'(TBL_ENTRIES));
    send_checked(noise_req(CMD_CLEAR));
    random_phase(80);

    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_resp.size() == 0)
      $display("tb_modbus_tcp_read_register_server OK");
    else
      $display("tb_modbus_tcp_read_register_server NOT OK");
    $finish;
  end

endmodule
